### rtl/core/mpfd_pkg.sv
package mpfd_pkg;

	localparam int DISPLAY_WIDTH_DEF  = 128;
	localparam int DISPLAY_HEIGHT_DEF = 64;
	localparam int CMD_W = 3;
	localparam int X_W   = 7;
	localparam int Y_W   = 6;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		CMD_SET    = 3'd0,
		CMD_GET    = 3'd1,
		CMD_XOR    = 3'd2,
		CMD_FILL   = 3'd3,
		CMD_BITMAP = 3'd4
	} cmd_t;

	// classified work for the back end
	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_GET  = 2'd1,
		OP_RECT = 2'd2
	} op_t;

	// a rect op covers columns x0..x1 over the pages that hold rows y0..y1; per byte the bit mask
	// comes from the row span, and per column the value/mask pattern
	typedef struct packed {
		op_t        op;
		logic [7:0] x0;
		logic [7:0] x1;
		logic [7:0] y0;
		logic [7:0] y1;
		logic       inv;    // invert rather than write
		logic [7:0] wmask;  // column pattern for bitmap: bit i = column x0+i active
		logic [7:0] wval;   // value for each bitmap column
		logic       bmp;    // use column pattern
		logic       val;    // fill value
	} work_t;

	typedef enum logic [1:0] {
		BS_IDLE  = 2'd0,
		BS_READ  = 2'd1,
		BS_WRITE = 2'd2,
		BS_CLEAR = 2'd3
	} bstate_t;

endpackage

### rtl/core/mpfd_if.sv
interface mpfd_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [6:0] x_start;
	logic [5:0] y_start;
	logic [6:0] x_end;
	logic [5:0] y_end;
	logic       pixel_value;
	logic [7:0] bitmap_bits;
	logic [2:0] first_bit;
	logic [3:0] pixel_count;
	logic       fg_index;
	logic       bg_index;
	modport source (output valid, cmd, x_start, y_start, x_end, y_end, pixel_value,
		bitmap_bits, first_bit, pixel_count, fg_index, bg_index, input ready);
	modport sink (input valid, cmd, x_start, y_start, x_end, y_end, pixel_value,
		bitmap_bits, first_bit, pixel_count, fg_index, bg_index, output ready);
endinterface

interface mpfd_out_if;
	logic valid;
	logic ready;
	logic read_bit;
	modport source (output valid, read_bit, input ready);
	modport sink (input valid, read_bit, output ready);
endinterface

### rtl/core/mpfd_ram.sv
module mpfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/core/mpfd_front.sv
module mpfd_front (
	input  logic           xor_mode,
	input  logic           transparent_mode,
	mpfd_in_if.sink        in_ch,
	input  logic           q_full,
	output logic           q_push,
	output mpfd_pkg::work_t q_data
);
	import mpfd_pkg::*;

	logic [3:0] limit, cnt;
	logic [7:0] act, bitv;
	logic [7:0] xs8;

	assign in_ch.ready = !q_full;
	assign q_push = in_ch.valid && !q_full;
	assign xs8 = {1'b0, in_ch.x_start};

	always_comb begin
		limit = 4'd8 - {1'b0, in_ch.first_bit};
		cnt = (in_ch.pixel_count > limit) ? limit : in_ch.pixel_count;
		// column i of the 8-wide span starting at x_start
		for (int i = 0; i < 8; i++) begin
			act[i]  = (4'(i) >= {1'b0, in_ch.first_bit}) &&
				(4'(i) < {1'b0, in_ch.first_bit} + cnt);
			bitv[i] = in_ch.bitmap_bits[7-i];
			if (xor_mode || transparent_mode) act[i] = act[i] && bitv[i];
		end
	end

	always_comb begin
		q_data = '0;
		q_data.x0 = xs8;
		q_data.y0 = {2'b0, in_ch.y_start};
		q_data.x1 = xs8;
		q_data.y1 = {2'b0, in_ch.y_start};
		unique case (in_ch.cmd)
			CMD_SET: begin
				q_data.op = OP_RECT;
				q_data.val = in_ch.pixel_value;
			end
			CMD_GET: q_data.op = OP_GET;
			CMD_XOR: begin
				q_data.op = OP_RECT;
				q_data.inv = 1'b1;
			end
			CMD_FILL: begin
				q_data.op = (in_ch.x_end < in_ch.x_start || in_ch.y_end < in_ch.y_start)
					? OP_NONE : OP_RECT;
				q_data.x1 = {1'b0, in_ch.x_end};
				q_data.y1 = {2'b0, in_ch.y_end};
				q_data.inv = xor_mode;
				q_data.val = in_ch.pixel_value;
			end
			CMD_BITMAP: begin
				q_data.op = (act == 8'd0) ? OP_NONE : OP_RECT;
				q_data.x1 = xs8 + 8'd7;
				q_data.bmp = 1'b1;
				q_data.inv = xor_mode;
				q_data.wmask = act;
				for (int i = 0; i < 8; i++)
					q_data.wval[i] = bitv[i] ? in_ch.fg_index : in_ch.bg_index;
			end
			default: q_data.op = OP_NONE;
		endcase
	end
endmodule

### rtl/core/mpfd_queue.sv
module mpfd_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mpfd_pkg::work_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output mpfd_pkg::work_t rdata
);
	import mpfd_pkg::*;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	work_t          buf_q [DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [AW:0]    cnt_q;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = buf_q[rp_q];

	always_ff @(posedge clk) if (push) buf_q[wp_q] <= wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue count out of range");
`endif
endmodule

### rtl/core/mpfd_back.sv
module mpfd_back #(
	parameter int DISPLAY_WIDTH  = mpfd_pkg::DISPLAY_WIDTH_DEF,
	parameter int DISPLAY_HEIGHT = mpfd_pkg::DISPLAY_HEIGHT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  mpfd_pkg::work_t q_data,
	output logic            q_pop,
	mpfd_out_if.source      out_ch
);
	import mpfd_pkg::*;
	localparam int PAGES = (DISPLAY_HEIGHT + 7) / 8;
	localparam int DEPTH = DISPLAY_WIDTH * PAGES;
	localparam int AW = $clog2(DEPTH);

	bstate_t state_q, state_d;
	logic [8:0]    cx_q, cx_d;   // current column, wide enough for x0+7
	logic [5:0]    pg_q, pg_d;   // current page
	logic [AW-1:0] clr_q;
	logic          ov_q, rb_q;
	logic [8:0]    xlast;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata, bmask;
	logic [2:0]    col;
	logic          col_on, row_ok, x_ok, last_col, last_pg, fire;
	logic [7:0]    ylo, yhi;

	// clip rectangle to the display; bitmap columns may run past the right edge
	always_comb begin
		xlast = {1'b0, q_data.x1};
		if (xlast > 9'(DISPLAY_WIDTH - 1)) xlast = 9'(DISPLAY_WIDTH - 1);
		yhi = (q_data.y1 > 8'(DISPLAY_HEIGHT - 1)) ? 8'(DISPLAY_HEIGHT - 1) : q_data.y1;
		ylo = q_data.y0;
		row_ok = {1'b0, ylo} < 9'(DISPLAY_HEIGHT);
		x_ok = {1'b0, q_data.x0} < 9'(DISPLAY_WIDTH);
		for (int b = 0; b < 8; b++)
			bmask[b] = ({pg_q[4:0], 3'(b)} >= ylo) && ({pg_q[4:0], 3'(b)} <= yhi);
		col = 3'(cx_q - {1'b0, q_data.x0});
		col_on = q_data.bmp ? q_data.wmask[col] : 1'b1;
		last_col = (cx_q >= xlast);
		last_pg = ({2'b0, pg_q} >= 8'(yhi >> 3));
		raddr = AW'(pg_q) * AW'(DISPLAY_WIDTH) + AW'(cx_q);
	end

	always_comb begin
		state_d = state_q;
		cx_d = cx_q;
		pg_d = pg_q;
		we = 1'b0;
		waddr = raddr;
		wdata = rdata;
		q_pop = 1'b0;
		fire = 1'b0;
		unique case (state_q)
			BS_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (clr_q == AW'(DEPTH - 1)) state_d = BS_IDLE;
			end
			BS_IDLE: begin
				if (!q_empty && !ov_q) begin
					if (q_data.op == OP_RECT && (!row_ok || !x_ok)) begin
						q_pop = 1'b1;
						fire = 1'b1;
					end else if (q_data.op == OP_NONE) begin
						q_pop = 1'b1;
						fire = 1'b1;
					end else begin
						cx_d = {1'b0, q_data.x0};
						pg_d = 6'(ylo >> 3);
						state_d = BS_READ;
					end
				end
			end
			BS_READ: state_d = BS_WRITE;
			BS_WRITE: begin
				if (q_data.op == OP_GET) begin
					q_pop = 1'b1;
					fire = 1'b1;
					state_d = BS_IDLE;
				end else begin
					we = col_on;
					for (int b = 0; b < 8; b++)
						if (bmask[b])
							wdata[b] = q_data.inv ? ~rdata[b]
								: (q_data.bmp ? q_data.wval[col] : q_data.val);
					state_d = BS_READ;
					if (!last_col) cx_d = cx_q + 9'd1;
					else if (!last_pg) begin
						cx_d = {1'b0, q_data.x0};
						pg_d = pg_q + 6'd1;
					end else begin
						q_pop = 1'b1;
						fire = 1'b1;
						state_d = BS_IDLE;
					end
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_CLEAR;
			clr_q <= '0;
			ov_q <= 1'b0;
			cx_q <= '0;
			pg_q <= '0;
		end else begin
			state_q <= state_d;
			cx_q <= cx_d;
			pg_q <= pg_d;
			if (state_q == BS_CLEAR) clr_q <= clr_q + 1'b1;
			if (fire) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			rb_q <= (q_data.op == OP_GET) && row_ok && x_ok && rdata[ylo[2:0]];
	end

	assign out_ch.valid = ov_q;
	assign out_ch.read_bit = rb_q;

	mpfd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

`ifndef SYNTHESIS
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BS_CLEAR |-> !q_pop) else $error("pop during clear");
	a_fire_once: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> !ov_q) else $error("result overwritten");
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BS_WRITE |-> $past(state_q) == BS_READ) else $error("write without read");
`endif
endmodule

### rtl/core/mono_page_framebuffer_draw.sv
// pixel commands and get pass the read and write states before their result; clipped or empty
// items give it from idle; each store byte is read, then written; no item starts until the
// last result is taken; a fill reads and writes each column on each touched page, a bitmap
// each of its 8 columns on the display; after reset the store is cleared, one byte a cycle,
// 1024 bytes at default size, while items queue but none execute; mode registers reset to 0
module mono_page_framebuffer_draw #(
	parameter int DISPLAY_WIDTH  = mpfd_pkg::DISPLAY_WIDTH_DEF,
	parameter int DISPLAY_HEIGHT = mpfd_pkg::DISPLAY_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic        cfg_data,
	mpfd_in_if.sink     in_ch,
	mpfd_out_if.source  out_ch
);
	import mpfd_pkg::*;

	logic  xor_mode_q, transparent_mode_q;
	logic  q_full, q_push, q_pop, q_empty;
	work_t q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_mode_q <= 1'b0;
			transparent_mode_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) xor_mode_q <= cfg_data;
			else transparent_mode_q <= cfg_data;
		end
	end

	mpfd_front u_front (
		.xor_mode(xor_mode_q),
		.transparent_mode(transparent_mode_q), .in_ch(in_ch),
		.q_full(q_full), .q_push(q_push), .q_data(q_wdata)
	);

	mpfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .wdata(q_wdata), .full(q_full),
		.pop(q_pop), .empty(q_empty), .rdata(q_rdata)
	);

	mpfd_back #(.DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_HEIGHT(DISPLAY_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(q_rdata),
		.q_pop(q_pop), .out_ch(out_ch)
	);
endmodule

### bench/mpfd_test_if.sv
`timescale 1ns / 100ps

// no separate interface needed beyond the rtl ones; channel helpers only
package mpfd_test_pkg;
	import mpfd_pkg::*;

	typedef struct {
		logic [2:0] cmd;
		logic [6:0] x_start;
		logic [5:0] y_start;
		logic [6:0] x_end;
		logic [5:0] y_end;
		logic       pixel_value;
		logic [7:0] bitmap_bits;
		logic [2:0] first_bit;
		logic [3:0] pixel_count;
		logic       fg_index;
		logic       bg_index;
	} draw_item_t;
endpackage

### bench/mono_page_framebuffer_draw_test.sv
`timescale 1ns / 100ps

module mono_page_framebuffer_draw_test;
	import mpfd_pkg::*;
	import mpfd_test_pkg::*;

	localparam int WIDTH = 128;
	localparam int HEIGHT = 64;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [0:0] REG_XOR = 1'b0;
	localparam logic [0:0] REG_TRANSPARENT = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic cfg_data = 1'b0;

	mpfd_in_if in_ch ();
	mpfd_out_if out_ch ();

	mono_page_framebuffer_draw i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always #2 clk = ~clk;

	// shadow of the frame, one bit per pixel
	logic pixels [WIDTH][HEIGHT];
	logic xor_on = 1'b0;
	logic transparent_on = 1'b0;
	logic read_bits_due [$];
	int fail_count = 0;
	int idle_cycles = 0;
	logic stall_on = 1'b0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.cmd = '0;
		in_ch.x_start = '0;
		in_ch.y_start = '0;
		in_ch.x_end = '0;
		in_ch.y_end = '0;
		in_ch.pixel_value = 1'b0;
		in_ch.bitmap_bits = '0;
		in_ch.first_bit = '0;
		in_ch.pixel_count = '0;
		in_ch.fg_index = 1'b0;
		in_ch.bg_index = 1'b0;
		out_ch.ready = 1'b0;
		for (int x = 0; x < WIDTH; x++)
			for (int y = 0; y < HEIGHT; y++)
				pixels[x][y] = 1'b0;
	end

	function automatic void put_pixel(int x, int y, logic v);
		if (x < WIDTH && y < HEIGHT)
			pixels[x][y] = v;
	endfunction

	function automatic logic pixel_at(int x, int y);
		if (x < WIDTH && y < HEIGHT)
			return pixels[x][y];
		return 1'b0;
	endfunction

	function automatic logic apply_draw(draw_item_t it);
		int span;
		int col;
		logic one;
		logic rb;
		rb = 1'b0;
		case (it.cmd)
			CMD_SET: put_pixel(it.x_start, it.y_start, it.pixel_value);
			CMD_GET: rb = pixel_at(it.x_start, it.y_start);
			CMD_XOR: put_pixel(it.x_start, it.y_start, ~pixel_at(it.x_start, it.y_start));
			CMD_FILL: begin
				if (it.x_end >= it.x_start && it.y_end >= it.y_start)
					for (int y = it.y_start; y <= it.y_end; y++)
						for (int x = it.x_start; x <= it.x_end; x++)
							put_pixel(x, y, xor_on ? ~pixel_at(x, y) : it.pixel_value);
			end
			CMD_BITMAP: begin
				span = int'(it.pixel_count);
				if (span > 8 - int'(it.first_bit))
					span = 8 - int'(it.first_bit);
				for (int i = 0; i < span; i++) begin
					col = int'(it.x_start) + int'(it.first_bit) + i;
					one = it.bitmap_bits[7 - (int'(it.first_bit) + i)];
					if (xor_on) begin
						if (one)
							put_pixel(col, it.y_start, ~pixel_at(col, it.y_start));
					end else if (transparent_on) begin
						if (one)
							put_pixel(col, it.y_start, it.fg_index);
					end else begin
						put_pixel(col, it.y_start, one ? it.fg_index : it.bg_index);
					end
				end
			end
			default: ;
		endcase
		return rb;
	endfunction

	// receiver stall pattern and result check
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 15) == 0)
				stall_on <= ~stall_on;
			out_ch.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	always @(posedge clk) begin
		logic expected_bit;
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_ch.valid && out_ch.ready) begin
				if (read_bits_due.size() == 0) begin
					$error("read_bit: unexpected item, actual %0b", out_ch.read_bit);
					fail_count++;
				end else begin
					expected_bit = read_bits_due.pop_front();
					if (out_ch.read_bit !== expected_bit) begin
						$error("read_bit: expected %0b actual %0b", expected_bit,
							out_ch.read_bit);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// driven with blocking assignments at the falling edge so that dropping valid
	// and raising it for the next item in the same step leaves one value
	task automatic send_draw(draw_item_t it);
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.cmd = it.cmd;
		in_ch.x_start = it.x_start;
		in_ch.y_start = it.y_start;
		in_ch.x_end = it.x_end;
		in_ch.y_end = it.y_end;
		in_ch.pixel_value = it.pixel_value;
		in_ch.bitmap_bits = it.bitmap_bits;
		in_ch.first_bit = it.first_bit;
		in_ch.pixel_count = it.pixel_count;
		in_ch.fg_index = it.fg_index;
		in_ch.bg_index = it.bg_index;
		do @(posedge clk); while (!in_ch.ready);
		read_bits_due.push_back(apply_draw(it));
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic drain_results();
		while (read_bits_due.size() != 0)
			@(negedge clk);
		// a fill can run over every page of the full width
		repeat (2200) @(negedge clk);
	endtask

	task automatic write_modes(logic xor_value, logic transparent_value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= REG_XOR;
		cfg_data <= xor_value;
		@(negedge clk);
		cfg_index <= REG_TRANSPARENT;
		cfg_data <= transparent_value;
		@(negedge clk);
		cfg_we <= 1'b0;
		xor_on = xor_value;
		transparent_on = transparent_value;
	endtask

	function automatic draw_item_t random_draw(bit small_fill);
		draw_item_t it;
		int r;
		it.cmd = 3'($urandom_range(0, 7));
		r = $urandom_range(0, 9);
		if (r < 3)
			it.cmd = CMD_GET;
		else if (r < 5)
			it.cmd = CMD_BITMAP;
		it.x_start = 7'($urandom());
		it.y_start = 6'($urandom());
		it.x_end = 7'($urandom());
		it.y_end = 6'($urandom());
		if (small_fill && it.cmd == CMD_FILL) begin
			it.x_end = 7'(int'(it.x_start) + int'($urandom_range(0, 10)) - 1);
			it.y_end = 6'(int'(it.y_start) + int'($urandom_range(0, 12)) - 1);
		end
		it.pixel_value = 1'($urandom());
		it.bitmap_bits = 8'($urandom());
		it.first_bit = 3'($urandom());
		it.pixel_count = 4'($urandom_range(0, 15));
		it.fg_index = 1'($urandom());
		it.bg_index = 1'($urandom());
		return it;
	endfunction

	function automatic draw_item_t make_draw(logic [2:0] c, int xs, int ys, int xe, int ye,
		logic pv);
		draw_item_t it;
		it = random_draw(1'b1);
		it.cmd = c;
		it.x_start = 7'(xs);
		it.y_start = 6'(ys);
		it.x_end = 7'(xe);
		it.y_end = 6'(ye);
		it.pixel_value = pv;
		return it;
	endfunction

	task automatic test_pixels();
		send_draw(make_draw(CMD_GET, 127, 63, 0, 0, 0));
		send_draw(make_draw(CMD_SET, 0, 0, 0, 0, 1));
		send_draw(make_draw(CMD_SET, 127, 63, 0, 0, 1));
		send_draw(make_draw(CMD_GET, 0, 0, 0, 0, 0));
		send_draw(make_draw(CMD_GET, 127, 63, 0, 0, 0));
		send_draw(make_draw(CMD_XOR, 127, 63, 0, 0, 0));
		send_draw(make_draw(CMD_GET, 127, 63, 0, 0, 0));
		send_draw(make_draw(CMD_XOR, 5, 7, 0, 0, 0));
		send_draw(make_draw(CMD_GET, 5, 7, 0, 0, 0));
		send_draw(make_draw(3'd5, 5, 7, 0, 0, 0));
		send_draw(make_draw(3'd7, 5, 7, 0, 0, 0));
	endtask

	task automatic test_fills();
		send_draw(make_draw(CMD_FILL, 0, 0, 127, 63, 1));
		send_draw(make_draw(CMD_GET, 64, 33, 0, 0, 0));
		send_draw(make_draw(CMD_FILL, 10, 3, 9, 20, 0));
		send_draw(make_draw(CMD_FILL, 10, 20, 30, 3, 0));
		send_draw(make_draw(CMD_FILL, 3, 5, 20, 14, 0));
		send_draw(make_draw(CMD_GET, 10, 9, 0, 0, 0));
	endtask

	task automatic test_bitmaps();
		draw_item_t it;
		it = make_draw(CMD_BITMAP, 124, 62, 0, 0, 0);
		it.bitmap_bits = 8'hA5;
		it.first_bit = 3'd2;
		it.pixel_count = 4'd15;
		it.fg_index = 1'b1;
		it.bg_index = 1'b0;
		send_draw(it);
		it.pixel_count = 4'd0;
		send_draw(it);
		it.x_start = 7'd0;
		it.first_bit = 3'd0;
		it.pixel_count = 4'd8;
		it.bitmap_bits = 8'h5A;
		it.fg_index = 1'b0;
		it.bg_index = 1'b1;
		send_draw(it);
		send_draw(make_draw(CMD_GET, 1, 62, 0, 0, 0));
		send_draw(make_draw(CMD_GET, 127, 62, 0, 0, 0));
	endtask

	task automatic test_random(int count);
		int burst;
		int sent;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 30);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_draw(random_draw($urandom_range(0, 30) != 0));
				sent++;
			end
			if ($urandom_range(0, 1))
				repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	task automatic test_wait_for_results();
		while (read_bits_due.size() != 0)
			@(negedge clk);
		test_random(20);
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_pixels();
		test_fills();
		test_bitmaps();
		test_random(180);
		test_wait_for_results();
		write_modes(1'b0, 1'b1);
		test_bitmaps();
		test_random(110);
		write_modes(1'b1, 1'b0);
		test_fills();
		test_bitmaps();
		test_random(110);
		write_modes(1'b1, 1'b1);
		test_random(110);
		write_modes(1'b0, 1'b0);
		test_random(70);
		drain_results();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
